FILE: rtl/u8u16_pkg.sv
package u8u16_pkg;

  typedef struct packed {
    logic load;       // take the input request into the window
    logic drop_one;   // discard the front byte
    logic emit;       // consume a complete sequence, load its first unit
    logic emit_low;   // load the held low surrogate
    logic emit_term;  // load the zero terminator
    logic emit_mark;  // load the bare end marker
    logic clear;      // empty the window
  } ctl_cmd_t;

  typedef struct packed {
    logic empty;       // no bytes held
    logic incomplete;  // front sequence still waits for bytes
    logic bad;         // front byte is no start byte or a continuation is wrong
    logic wide;        // code point needs a surrogate pair
    logic out_free;    // output register can take a unit this cycle
  } dp_stat_t;

  // sequence length announced by a start byte, 0 for no start byte
  function automatic logic [2:0] seq_len(input logic [7:0] c);
    logic [2:0] len;
    len = 3'd0;
    if ((c & 8'h80) == 8'h00) len = 3'd1;
    else if ((c & 8'hE0) == 8'hC0) len = 3'd2;
    else if ((c & 8'hF0) == 8'hE0) len = 3'd3;
    else if ((c & 8'hF8) == 8'hF0) len = 3'd4;
    return len;
  endfunction

  function automatic logic is_cont(input logic [7:0] c);
    return (c & 8'hC0) == 8'h80;
  endfunction

endpackage

FILE: rtl/u8u16_dp.sv
module u8u16_dp (
  input  logic               clk,
  input  logic               rst,
  input  u8u16_pkg::ctl_cmd_t cmd,
  output u8u16_pkg::dp_stat_t stat,
  input  logic               has_byte,
  input  logic [7:0]         byte_in,
  input  logic               m_tready,
  output logic               m_tvalid,
  output logic [15:0]        m_tdata,
  output logic               m_tlast,
  output logic               m_tuser
);
  import u8u16_pkg::*;

  logic [7:0]  window_bytes [4];
  logic [2:0]  held_count;
  logic [15:0] low_unit;

  logic        out_valid;
  logic [15:0] out_unit;
  logic        out_uv;
  logic        out_last;

  logic [2:0]  len;
  logic        cont_ok;
  logic [20:0] cp;
  logic [20:0] cp_off;
  logic [15:0] hi_unit;
  logic [15:0] lo_unit_next;
  logic [2:0]  drop_k;
  logic        do_drop;

  always_comb begin
    len = seq_len(window_bytes[0]);
    cont_ok = (len < 3'd2 || is_cont(window_bytes[1])) &&
              (len < 3'd3 || is_cont(window_bytes[2])) &&
              (len < 3'd4 || is_cont(window_bytes[3]));
    case (len)
      3'd1:    cp = {13'd0, window_bytes[0]};
      3'd2:    cp = {10'd0, window_bytes[0][4:0], window_bytes[1][5:0]};
      3'd3:    cp = {5'd0, window_bytes[0][3:0], window_bytes[1][5:0],
                     window_bytes[2][5:0]};
      default: cp = {window_bytes[0][2:0], window_bytes[1][5:0],
                     window_bytes[2][5:0], window_bytes[3][5:0]};
    endcase
    cp_off       = cp - 21'h10000;
    hi_unit      = 16'hD800 + {5'd0, cp_off[20:10]};
    lo_unit_next = 16'hDC00 + {6'd0, cp_off[9:0]};
  end

  always_comb begin
    stat.empty      = held_count == 3'd0;
    stat.incomplete = len != 3'd0 && held_count < len;
    stat.bad        = len == 3'd0 || !cont_ok;
    stat.wide       = cp > 21'h00FFFF;
    stat.out_free   = !out_valid || m_tready;
  end

  always_comb begin
    do_drop = cmd.drop_one || cmd.emit;
    drop_k  = cmd.emit ? len : 3'd1;
  end

  // window shifts toward the front on a drop
  always_ff @(posedge clk) begin
    if (cmd.load && has_byte && held_count < 3'd4) begin
      window_bytes[held_count[1:0]] <= byte_in;
    end else if (do_drop) begin
      case (drop_k)
        3'd1: begin
          window_bytes[0] <= window_bytes[1];
          window_bytes[1] <= window_bytes[2];
          window_bytes[2] <= window_bytes[3];
        end
        3'd2: begin
          window_bytes[0] <= window_bytes[2];
          window_bytes[1] <= window_bytes[3];
        end
        3'd3: begin
          window_bytes[0] <= window_bytes[3];
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      held_count <= 3'd0;
    end else if (cmd.clear) begin
      held_count <= 3'd0;
    end else if (cmd.load && has_byte && held_count < 3'd4) begin
      held_count <= held_count + 3'd1;
    end else if (do_drop) begin
      held_count <= (drop_k > held_count) ? 3'd0 : held_count - drop_k;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      low_unit <= lo_unit_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit || cmd.emit_low || cmd.emit_term || cmd.emit_mark) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_unit <= stat.wide ? hi_unit : cp[15:0];
      out_uv   <= 1'b1;
      out_last <= 1'b0;
    end else if (cmd.emit_low) begin
      out_unit <= low_unit;
      out_uv   <= 1'b1;
      out_last <= 1'b0;
    end else if (cmd.emit_term) begin
      out_unit <= 16'd0;
      out_uv   <= 1'b1;
      out_last <= 1'b0;
    end else if (cmd.emit_mark) begin
      out_unit <= 16'd0;
      out_uv   <= 1'b0;
      out_last <= 1'b1;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = out_unit;
  assign m_tuser  = out_uv;
  assign m_tlast  = out_last;

endmodule

FILE: rtl/u8u16_ctrl.sv
module u8u16_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic                has_byte,
  input  logic                end_of_string,
  input  logic                cfg_wr_en,
  input  logic                cfg_wr_data,
  input  u8u16_pkg::dp_stat_t stat,
  output u8u16_pkg::ctl_cmd_t cmd
);
  import u8u16_pkg::*;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_SCAN = 3'd1;
  localparam logic [2:0] ST_LOW  = 3'd2;
  localparam logic [2:0] ST_TERM = 3'd3;
  localparam logic [2:0] ST_MARK = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       pend_end;
  logic       pend_end_next;
  logic       null_terminate;
  logic       accept;

  assign s_tready = state == ST_IDLE;
  assign accept   = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      null_terminate <= 1'b1;
    end else if (cfg_wr_en) begin
      null_terminate <= cfg_wr_data;
    end
  end

  always_comb begin
    cmd           = '0;
    state_next    = state;
    pend_end_next = pend_end;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          cmd.load      = 1'b1;
          pend_end_next = end_of_string;
          if (has_byte) state_next = ST_SCAN;
          else if (end_of_string) state_next = ST_TERM;
        end
      end
      ST_SCAN: begin
        if (stat.empty || stat.incomplete) begin
          state_next = pend_end ? ST_TERM : ST_IDLE;
        end else if (stat.bad) begin
          cmd.drop_one = 1'b1;
        end else if (stat.out_free) begin
          cmd.emit = 1'b1;
          if (stat.wide) state_next = ST_LOW;
        end
      end
      ST_LOW: begin
        if (stat.out_free) begin
          cmd.emit_low = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_TERM: begin
        // a cut-off sequence is thrown away here
        cmd.clear = 1'b1;
        if (!null_terminate) begin
          state_next = ST_MARK;
        end else if (stat.out_free) begin
          cmd.emit_term = 1'b1;
          state_next    = ST_MARK;
        end
      end
      ST_MARK: begin
        if (stat.out_free) begin
          cmd.emit_mark = 1'b1;
          pend_end_next = 1'b0;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      pend_end <= 1'b0;
    end else begin
      state    <= state_next;
      pend_end <= pend_end_next;
    end
  end

endmodule

FILE: rtl/utf8_to_utf16_transcoder_core.sv
// channel   dir  tdata              tuser          tlast
// s_axis    in   byte_in[7:0]       has_byte       end_of_string
// m_axis    out  code_unit[15:0]    unit_valid     final_unit
// cfg       in   cfg_wr_data = null_terminate, written when cfg_wr_en is high
//
// one request at a time: after the accept, the scan loop drops each bad byte and
// emits each complete sequence (a surrogate pair through ST_LOW), then goes
// back to idle, or at end of string through ST_TERM (zero terminator when
// null_terminate is set) and ST_MARK (bare end marker)
// rst is synchronous, active high, and empties the window; null_terminate resets to 1
// a stalled m_tready holds the scan loop at its next unit, s_tready is high only while idle
module utf8_to_utf16_transcoder_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] byte_in
  input  logic        s_tuser,   // [0] has_byte
  input  logic        s_tlast,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // [15:0] code_unit
  output logic        m_tuser,   // [0] unit_valid
  output logic        m_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data
);
  import u8u16_pkg::*;

  ctl_cmd_t cmd;
  dp_stat_t stat;

  u8u16_ctrl u_ctrl (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .has_byte      (s_tuser),
    .end_of_string (s_tlast),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .stat          (stat),
    .cmd           (cmd)
  );

  u8u16_dp u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .has_byte (s_tuser),
    .byte_in  (s_tdata),
    .m_tready (m_tready),
    .m_tvalid (m_tvalid),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

FILE: rtl/u8u16_checker.sv
module u8u16_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic        s_tuser,
  input logic        s_tlast,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [15:0] m_tdata,
  input logic        m_tuser,
  input logic        m_tlast
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("output request dropped while stalled");

  a_mark_form: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> !m_tuser && m_tdata == 16'd0)
    else $error("end marker carries a unit");

  a_bare_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tlast)
    else $error("bare result without end flag");

  a_busy_after_req: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser || s_tlast) |=> !s_tready)
    else $error("input taken again before work finished");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser) && $stable(m_tlast))
    else $error("output request changed while stalled");

endmodule

bind utf8_to_utf16_transcoder_core u8u16_checker u_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tuser  (s_tuser),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);

FILE: bench/utf8_to_utf16_transcoder_core_tb.sv
module utf8_to_utf16_transcoder_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SETTLE_CYCLES = 20;
  localparam int HOLD_CYCLES = 300;
  localparam int STALL_LIMIT = 3000;
  localparam int PHASE_ITEMS = 97;

  typedef struct packed {
    logic        unit_valid;
    logic [15:0] code_unit;
    logic        final_unit;
  } utf16_unit_t;

  class transcode_scoreboard;
    bit [7:0]    held_bytes[4];
    int unsigned held_count;
    bit          null_term;
    utf16_unit_t expected_units[$];
    int          mismatches;

    function new();
      held_count = 0;
      null_term = 1'b1;
      mismatches = 0;
    endfunction

    function int pending();
      return expected_units.size();
    endfunction

    function int unsigned lead_length(bit [7:0] b);
      casez (b)
        8'b0???????: return 1;
        8'b110?????: return 2;
        8'b1110????: return 3;
        8'b11110???: return 4;
        default:     return 0;
      endcase
    endfunction

    function void shift_out(int unsigned k);
      for (int i = 0; i + k < 4; i++) begin
        held_bytes[i] = held_bytes[i + k];
      end
      held_count -= k;
    endfunction

    function void add_unit(bit v, bit [15:0] u, bit f);
      utf16_unit_t r;
      r.unit_valid = v;
      r.code_unit = u;
      r.final_unit = f;
      expected_units = {expected_units, r};
    endfunction

    // decode whatever complete sequences sit at the front of the window, dropping bad bytes
    function void resolve_window();
      int unsigned len;
      int unsigned cp;
      bit ok;
      while (held_count > 0) begin
        len = lead_length(held_bytes[0]);
        if (len == 0) begin
          shift_out(1);
          continue;
        end
        if (held_count < len) break;
        ok = 1'b1;
        case (len)
          1: cp = held_bytes[0];
          2: cp = held_bytes[0] & 8'h1F;
          3: cp = held_bytes[0] & 8'h0F;
          default: cp = held_bytes[0] & 8'h07;
        endcase
        for (int k = 1; k < len; k++) begin
          if (held_bytes[k][7:6] != 2'b10) begin
            ok = 1'b0;
            break;
          end
          cp = (cp << 6) | held_bytes[k][5:0];
        end
        if (!ok) begin
          shift_out(1);
          continue;
        end
        shift_out(len);
        if (cp <= 32'hFFFF) begin
          add_unit(1'b1, cp[15:0], 1'b0);
        end else begin
          cp -= 32'h10000;
          add_unit(1'b1, 16'(32'hD800 + (cp >> 10)), 1'b0);
          add_unit(1'b1, 16'(32'hDC00 + (cp & 32'h3FF)), 1'b0);
        end
      end
    endfunction

    function void note_request(bit has_byte, bit [7:0] data_byte, bit eos);
      if (has_byte) begin
        if (held_count < 4) begin
          held_bytes[held_count] = data_byte;
          held_count++;
        end
        resolve_window();
      end
      if (eos) begin
        held_count = 0;
        if (null_term) add_unit(1'b1, 16'h0000, 1'b0);
        add_unit(1'b0, 16'h0000, 1'b1);
      end
    endfunction

    function void check_unit(logic v, logic [15:0] u, logic f);
      utf16_unit_t want;
      if (expected_units.size() == 0) begin
        $error("unexpected unit: unit_valid %0d code_unit %h final_unit %0d", v, u, f);
        mismatches++;
        return;
      end
      want = expected_units.pop_front();
      if (v !== want.unit_valid) begin
        $error("unit_valid: expected %0d, got %0d", want.unit_valid, v);
        mismatches++;
      end
      if (u !== want.code_unit) begin
        $error("code_unit: expected %h, got %h", want.code_unit, u);
        mismatches++;
      end
      if (f !== want.final_unit) begin
        $error("final_unit: expected %0d, got %0d", want.final_unit, f);
        mismatches++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;   // [7:0] byte_in
  logic        s_tuser;   // [0] has_byte
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [15:0] m_tdata;   // [15:0] code_unit
  logic        m_tuser;   // [0] unit_valid
  logic        m_tlast;
  logic        cfg_wr_en;
  logic        cfg_wr_data;

  transcode_scoreboard sb = new();
  bit hold_off = 1'b0;
  int items_sent = 0;
  int quiet_cycles = 0;

  utf8_to_utf16_transcoder_core dut (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser),
    .m_tlast    (m_tlast),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_unit(m_tuser, m_tdata, m_tlast);
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // receiver: ready stretches broken by stalls, plus one long hold-off on request
  initial begin
    int run_len;
    int stall_len;
    m_tready = 1'b0;
    @(negedge rst);
    forever begin
      if (hold_off) begin
        m_tready = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_off = 1'b0;
      end
      run_len = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 80) : $urandom_range(1, 6);
      m_tready = 1'b1;
      repeat (run_len) @(negedge clk);
      stall_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3) : $urandom_range(10, 40);
      m_tready = 1'b0;
      repeat (stall_len) @(negedge clk);
    end
  end

  task automatic send_request(input bit has_byte, input bit [7:0] data_byte, input bit eos,
                              input bit no_gaps);
    int gap;
    int pick;
    pick = $urandom_range(0, 9);
    gap = (no_gaps || pick < 6) ? 0 : (pick < 9) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    repeat (gap) begin
      @(negedge clk);
      s_tvalid = 1'b0;
    end
    @(negedge clk);
    s_tvalid = 1'b1;
    s_tuser = has_byte;
    s_tdata = data_byte;
    s_tlast = eos;
    do @(posedge clk); while (!s_tready);
    sb.note_request(has_byte, data_byte, eos);
    if (has_byte || eos) items_sent++;
  endtask

  task automatic idle_sender();
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic wait_drained();
    idle_sender();
    while (sb.pending() != 0) @(posedge clk);
    // a request with no unit may still be in the scan loop
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_null_terminate(input bit value);
    wait_drained();
    @(negedge clk);
    cfg_wr_en = 1'b1;
    cfg_wr_data = value;
    @(negedge clk);
    cfg_wr_en = 1'b0;
    sb.null_term = value;
  endtask

  function automatic bit [7:0] lead_byte(input int len);
    case (len)
      2: return 8'hC0 | 8'($urandom_range(0, 31));
      3: return 8'hE0 | 8'($urandom_range(0, 15));
      default: return 8'hF0 | 8'($urandom_range(0, 7));
    endcase
  endfunction

  task automatic send_random_string();
    bit [7:0] seq_bytes[$];
    int n_points;
    int kind;
    int len;
    bit no_gaps;
    bit eos_on_byte;
    bit [7:0] b;
    n_points = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 12);
    for (int i = 0; i < n_points; i++) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        seq_bytes = {seq_bytes, 8'($urandom_range(0, 127))};
      end else if (kind < 80) begin
        len = (kind < 50) ? 2 : (kind < 65) ? 3 : 4;
        seq_bytes = {seq_bytes, lead_byte(len)};
        repeat (len - 1) seq_bytes = {seq_bytes, 8'h80 | 8'($urandom_range(0, 63))};
      end else if (kind < 88) begin
        seq_bytes = {seq_bytes, 8'($urandom)};
      end else begin
        // truncated sequence, or one broken by a byte that is no continuation
        len = $urandom_range(2, 4);
        seq_bytes = {seq_bytes, lead_byte(len)};
        repeat ($urandom_range(0, len - 2)) begin
          seq_bytes = {seq_bytes, 8'h80 | 8'($urandom_range(0, 63))};
        end
        if (kind >= 94) begin
          b = 8'($urandom);
          if (b[7:6] == 2'b10) b[6] = 1'b1;
          seq_bytes = {seq_bytes, b};
        end
      end
    end
    no_gaps = ($urandom_range(0, 3) == 0);
    eos_on_byte = (seq_bytes.size() > 0) && ($urandom_range(0, 2) != 0);
    foreach (seq_bytes[j]) begin
      if ($urandom_range(0, 19) == 0) send_request(1'b0, 8'($urandom), 1'b0, no_gaps);
      send_request(1'b1, seq_bytes[j], eos_on_byte && (j == seq_bytes.size() - 1), no_gaps);
    end
    if (!eos_on_byte) send_request(1'b0, 8'($urandom), 1'b1, no_gaps);
  endtask

  task automatic run_random_phase(input int items_wanted);
    int target;
    target = items_sent + items_wanted;
    while (items_sent < target) send_random_string();
  endtask

  task automatic send_directed();
    bit [9:0] reqs[$];  // {has_byte, eos, byte}
    reqs = '{
      {2'b00, 8'h00},                                       // idle request
      {2'b10, 8'h00}, {2'b10, 8'h7F},
      {2'b10, 8'hC2}, {2'b10, 8'h80},
      {2'b10, 8'hEF}, {2'b10, 8'hBF}, {2'b10, 8'hBF},
      {2'b10, 8'hF4}, {2'b10, 8'h8F}, {2'b10, 8'hBF}, {2'b10, 8'hBF},
      {2'b10, 8'hFF}, {2'b10, 8'h80},                       // bad start bytes
      {2'b10, 8'hC2}, {2'b11, 8'h41},                       // broken continuation
      {2'b10, 8'hF7}, {2'b10, 8'hBF}, {2'b10, 8'hBF}, {2'b10, 8'hBF},
      {2'b10, 8'hE2}, {2'b10, 8'h82}, {2'b01, 8'hA5},       // cut off by the end
      {2'b01, 8'h5A}                                        // empty string
    };
    foreach (reqs[i]) send_request(reqs[i][9], reqs[i][7:0], reqs[i][8], 1'b0);
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = 8'h00;
    s_tuser = 1'b0;
    s_tlast = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = 1'b0;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    send_directed();
    write_null_terminate(1'b0);
    run_random_phase(PHASE_ITEMS);
    write_null_terminate(1'b1);
    hold_off = 1'b1;
    run_random_phase(PHASE_ITEMS);
    write_null_terminate(1'b0);
    run_random_phase(PHASE_ITEMS);
    write_null_terminate(1'b1);
    run_random_phase(PHASE_ITEMS);

    wait_drained();
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: utf8_to_utf16_transcoder_core.f
rtl/u8u16_pkg.sv
rtl/u8u16_dp.sv
rtl/u8u16_ctrl.sv
rtl/utf8_to_utf16_transcoder_core.sv
rtl/u8u16_checker.sv
bench/utf8_to_utf16_transcoder_core_tb.sv
